/* sv/das_pkg.sv */
package das_pkg;

    localparam int TimeW   = 32;
    localparam int InDataW = 40;
    localparam int OutDataW = 16;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WAIT = 2'd1;
    localparam logic [1:0] MODE_OPEN = 2'd2;

    localparam logic [1:0] CODE_OK        = 2'd1;
    localparam logic [1:0] CODE_NO        = 2'd2;
    localparam logic [1:0] CODE_NO_DETECT = 2'd3;

    localparam logic [1:0] SERVO_NONE  = 2'd0;
    localparam logic [1:0] SERVO_OPEN  = 2'd1;
    localparam logic [1:0] SERVO_CLOSE = 2'd2;

    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_WAITING    = 3'd1;
    localparam logic [2:0] ST_TIMEOUT    = 3'd2;
    localparam logic [2:0] ST_GRANTED    = 3'd3;
    localparam logic [2:0] ST_DENIED     = 3'd4;
    localparam logic [2:0] ST_READY      = 3'd5;
    localparam logic [2:0] ST_CLOSED     = 3'd6;
    localparam logic [2:0] ST_AUTOCLOSED = 3'd7;

    localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [1:0] REG_REPLY_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_DOOR_OPEN       = 2'd2;
    localparam logic [1:0] REG_ALERT_TIMEOUT   = 2'd3;

    localparam logic [TimeW-1:0] RST_SAMPLE_INTERVAL = 32'd500;
    localparam logic [TimeW-1:0] RST_REPLY_TIMEOUT   = 32'd10000;
    localparam logic [TimeW-1:0] RST_DOOR_OPEN       = 32'd5000;
    localparam logic [TimeW-1:0] RST_ALERT_TIMEOUT   = 32'd30000;

    typedef struct packed {
        logic [TimeW-1:0] sample_interval_ms;
        logic [TimeW-1:0] reply_timeout_ms;
        logic [TimeW-1:0] door_open_ms;
        logic [TimeW-1:0] alert_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       reply_code;
        logic             reply_arrived;
        logic             motion_level;
        logic [TimeW-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic [1:0] mode_now;
        logic [2:0] status_shown;
        logic       send_alert;
        logic [1:0] servo_command;
        logic       publish_motion;
    } t_result;

    typedef struct packed {
        logic [1:0]       mode;
        logic [TimeW-1:0] last_sample_time;
        logic [TimeW-1:0] door_move_time;
        logic [TimeW-1:0] wait_start_time;
        logic [TimeW-1:0] alert_start_time;
        logic             door_is_open;
        logic             grant_hold;
        logic             alert_latched;
        logic             alert_active;
        logic             prev_motion;
        logic             detect_enabled;
        logic             reply_pending;
        logic [1:0]       pending_code;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode:             MODE_IDLE,
        last_sample_time: '0,
        door_move_time:   '0,
        wait_start_time:  '0,
        alert_start_time: '0,
        door_is_open:     1'b0,
        grant_hold:       1'b0,
        alert_latched:    1'b0,
        alert_active:     1'b0,
        prev_motion:      1'b0,
        detect_enabled:   1'b1,
        reply_pending:    1'b0,
        pending_code:     2'b00
    };

endpackage

/* sv/door_access_sequencer.sv */
// Channel        Dir  Width  Contents
// s_axis         in   40     tdata: now_ms, motion_level, reply_arrived, reply_code
// m_axis         out  16     tdata: publish_motion, servo_command, send_alert,
//                            status_shown, mode_now
// i_cfg_*        in   1/2/32 write enable, register index, write data
//
// One tick per cycle sustained while m_axis is not stalled.
// The tick's work runs between the input register and the output register,
// and the control state is updated as the tick moves into the output register.
// Synchronous active-low reset sets the state and the config registers to their reset values and empties both stages.
// A stall on m_axis holds both stages; s_axis_tready drops while the input stage is full.
module door_access_sequencer
    import das_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,  // now_ms[31:0], motion_level[32],
                                               // reply_arrived[33], reply_code[35:34]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,  // publish_motion[0], servo_command[2:1],
                                               // send_alert[3], status_shown[6:4],
                                               // mode_now[8:7]
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [TimeW-1:0]    i_cfg_wdata
);

    localparam int ItemW = $bits(t_item);
    localparam int ResW  = $bits(t_result);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    t_result n_out_res;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_interval_ms <= RST_SAMPLE_INTERVAL;
            r_cfg.reply_timeout_ms   <= RST_REPLY_TIMEOUT;
            r_cfg.door_open_ms       <= RST_DOOR_OPEN;
            r_cfg.alert_timeout_ms   <= RST_ALERT_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SAMPLE_INTERVAL: r_cfg.sample_interval_ms <= i_cfg_wdata;
                REG_REPLY_TIMEOUT:   r_cfg.reply_timeout_ms   <= i_cfg_wdata;
                REG_DOOR_OPEN:       r_cfg.door_open_ms       <= i_cfg_wdata;
                REG_ALERT_TIMEOUT:   r_cfg.alert_timeout_ms   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    das_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= t_item'(s_axis_tdata[ItemW-1:0]);
        end
        if (advance) begin
            r_out_res <= n_out_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutDataW-ResW){1'b0}}, r_out_res};

endmodule

/* sv/das_step.sv */
module das_step
    import das_pkg::*;
(
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    t_state           s;
    t_result          r;
    logic [TimeW-1:0] now;
    logic             alert_done;
    logic             sample_due;
    logic             wait_expired;
    logic             open_expired;
    logic             auto_close;

    always_comb begin
        s   = i_state;
        now = i_item.now_ms;
        r   = '{mode_now: MODE_IDLE, status_shown: ST_NONE, send_alert: 1'b0,
                servo_command: SERVO_NONE, publish_motion: 1'b0};

        alert_done   = (now - i_state.alert_start_time) >= i_cfg.alert_timeout_ms;
        sample_due   = (now - i_state.last_sample_time) >= i_cfg.sample_interval_ms;
        wait_expired = (now - i_state.wait_start_time)  >= i_cfg.reply_timeout_ms;
        open_expired = (now - i_state.door_move_time)   >= i_cfg.door_open_ms;

        if (i_item.reply_arrived) begin
            s.reply_pending = 1'b1;
            s.pending_code  = i_item.reply_code;
        end

        if (s.alert_active && alert_done) begin
            s.alert_active   = 1'b0;
            s.alert_latched  = 1'b0;
            r.status_shown   = ST_READY;
            s.mode           = MODE_IDLE;
            s.detect_enabled = 1'b1;
        end

        unique case (s.mode)
            MODE_IDLE: begin
                if (s.detect_enabled && sample_due) begin
                    s.last_sample_time = now;
                    if (!s.prev_motion && i_item.motion_level) begin
                        r.publish_motion  = 1'b1;
                        r.status_shown    = ST_WAITING;
                        s.wait_start_time = now;
                        s.mode            = MODE_WAIT;
                        s.detect_enabled  = 1'b0;
                    end
                    s.prev_motion = i_item.motion_level;
                end
            end
            MODE_WAIT: begin
                if (wait_expired) begin
                    r.status_shown     = ST_TIMEOUT;
                    s.reply_pending    = 1'b0;
                    s.mode             = MODE_IDLE;
                    s.detect_enabled   = 1'b1;
                    s.last_sample_time = now;
                end else if (s.reply_pending) begin
                    if (s.pending_code == CODE_OK) begin
                        s.grant_hold   = 1'b1;
                        r.status_shown = ST_GRANTED;
                        if (!s.door_is_open) begin
                            r.servo_command  = SERVO_OPEN;
                            s.door_is_open   = 1'b1;
                            s.door_move_time = now;
                            s.mode           = MODE_OPEN;
                            s.grant_hold     = 1'b0;
                        end
                    end else if (s.pending_code == CODE_NO && !s.grant_hold) begin
                        r.status_shown = ST_DENIED;
                        if (!s.alert_latched && !s.alert_active) begin
                            s.alert_latched    = 1'b1;
                            s.alert_active     = 1'b1;
                            s.alert_start_time = now;
                            r.send_alert       = 1'b1;
                        end
                        s.mode             = MODE_IDLE;
                        s.detect_enabled   = 1'b1;
                        s.last_sample_time = now;
                    end else if (s.pending_code == CODE_NO_DETECT) begin
                        r.status_shown     = ST_READY;
                        s.mode             = MODE_IDLE;
                        s.detect_enabled   = 1'b1;
                        s.last_sample_time = now;
                    end
                    s.reply_pending = 1'b0;
                end
            end
            MODE_OPEN: begin
                if (open_expired) begin
                    r.servo_command    = SERVO_CLOSE;
                    s.door_is_open     = 1'b0;
                    r.status_shown     = ST_CLOSED;
                    s.mode             = MODE_IDLE;
                    s.detect_enabled   = 1'b1;
                    s.last_sample_time = now;
                    s.grant_hold       = 1'b0;
                    s.reply_pending    = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // door_move_time only changes on a move into open mode, which skips this
        auto_close = s.door_is_open && open_expired && (s.mode != MODE_OPEN);
        if (auto_close) begin
            r.servo_command    = SERVO_CLOSE;
            s.door_is_open     = 1'b0;
            r.status_shown     = ST_AUTOCLOSED;
            s.mode             = MODE_IDLE;
            s.detect_enabled   = 1'b1;
            s.last_sample_time = now;
            s.grant_hold       = 1'b0;
            s.reply_pending    = 1'b0;
        end

        r.mode_now = s.mode;
    end

    assign o_state  = s;
    assign o_result = r;

endmodule

/* sv/das_checker.sv */
module das_checker
    import das_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata
);

    t_result res;
    assign res = t_result'(m_axis_tdata[$bits(t_result)-1:0]);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without output stall");

    a_open_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.servo_command == SERVO_OPEN |-> res.mode_now == MODE_OPEN &&
            res.status_shown == ST_GRANTED)
        else $error("open command outside open mode");

    a_alert_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.send_alert |-> res.mode_now == MODE_IDLE &&
            (res.status_shown == ST_DENIED || res.status_shown == ST_AUTOCLOSED))
        else $error("alert without denial");

endmodule

bind door_access_sequencer das_checker u_das_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb_door_access_sequencer.sv */
module tb_door_access_sequencer;
    import das_pkg::*;

    localparam logic [1:0] CODE_UNKNOWN = 2'd0;
    localparam int unsigned QUIET_LIMIT = 3000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_idx = REG_SAMPLE_INTERVAL;
    logic [TimeW-1:0]    i_cfg_wdata = '0;

    door_access_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    t_item       tick_queue[$];
    t_result     expected_outputs[$];
    t_state      door_state = STATE_RESET;
    t_cfg        door_cfg = '{sample_interval_ms: RST_SAMPLE_INTERVAL,
                              reply_timeout_ms:   RST_REPLY_TIMEOUT,
                              door_open_ms:       RST_DOOR_OPEN,
                              alert_timeout_ms:   RST_ALERT_TIMEOUT};
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned recv_stall = 0;
    int unsigned recv_calm = 0;
    logic [TimeW-1:0] clock_ms = '0;
    logic             motion_lvl = 1'b0;

    function automatic logic ms_passed(input logic [TimeW-1:0] now, input logic [TimeW-1:0] stamp,
                                       input logic [TimeW-1:0] limit);
        logic [TimeW-1:0] diff;
        diff = now - stamp;
        return diff >= limit;
    endfunction

    function automatic void enter_idle(input logic [TimeW-1:0] now);
        door_state.mode = MODE_IDLE;
        door_state.detect_enabled = 1'b1;
        door_state.last_sample_time = now;
    endfunction

    function automatic t_result tick_outputs(input t_item it);
        t_result res;
        res.publish_motion = 1'b0;
        res.servo_command = SERVO_NONE;
        res.send_alert = 1'b0;
        res.status_shown = ST_NONE;
        if (it.reply_arrived) begin
            door_state.reply_pending = 1'b1;
            door_state.pending_code = it.reply_code;
        end
        if (door_state.alert_active &&
            ms_passed(it.now_ms, door_state.alert_start_time, door_cfg.alert_timeout_ms)) begin
            door_state.alert_active = 1'b0;
            door_state.alert_latched = 1'b0;
            res.status_shown = ST_READY;
            door_state.mode = MODE_IDLE;
            door_state.detect_enabled = 1'b1;
        end
        case (door_state.mode)
            MODE_IDLE: begin
                if (door_state.detect_enabled &&
                    ms_passed(it.now_ms, door_state.last_sample_time,
                              door_cfg.sample_interval_ms)) begin
                    door_state.last_sample_time = it.now_ms;
                    if (!door_state.prev_motion && it.motion_level) begin
                        res.publish_motion = 1'b1;
                        res.status_shown = ST_WAITING;
                        door_state.wait_start_time = it.now_ms;
                        door_state.mode = MODE_WAIT;
                        door_state.detect_enabled = 1'b0;
                    end
                    door_state.prev_motion = it.motion_level;
                end
            end
            MODE_WAIT: begin
                if (ms_passed(it.now_ms, door_state.wait_start_time,
                              door_cfg.reply_timeout_ms)) begin
                    res.status_shown = ST_TIMEOUT;
                    door_state.reply_pending = 1'b0;
                    enter_idle(it.now_ms);
                end else if (door_state.reply_pending) begin
                    if (door_state.pending_code == CODE_OK) begin
                        door_state.grant_hold = 1'b1;
                        res.status_shown = ST_GRANTED;
                        if (!door_state.door_is_open) begin
                            res.servo_command = SERVO_OPEN;
                            door_state.door_is_open = 1'b1;
                            door_state.door_move_time = it.now_ms;
                            door_state.mode = MODE_OPEN;
                            door_state.grant_hold = 1'b0;
                        end
                    end else if (door_state.pending_code == CODE_NO && !door_state.grant_hold) begin
                        res.status_shown = ST_DENIED;
                        if (!door_state.alert_latched && !door_state.alert_active) begin
                            door_state.alert_latched = 1'b1;
                            door_state.alert_active = 1'b1;
                            door_state.alert_start_time = it.now_ms;
                            res.send_alert = 1'b1;
                        end
                        enter_idle(it.now_ms);
                    end else if (door_state.pending_code == CODE_NO_DETECT) begin
                        res.status_shown = ST_READY;
                        enter_idle(it.now_ms);
                    end
                    door_state.reply_pending = 1'b0;
                end
            end
            MODE_OPEN: begin
                if (ms_passed(it.now_ms, door_state.door_move_time, door_cfg.door_open_ms)) begin
                    res.servo_command = SERVO_CLOSE;
                    door_state.door_is_open = 1'b0;
                    res.status_shown = ST_CLOSED;
                    enter_idle(it.now_ms);
                    door_state.grant_hold = 1'b0;
                    door_state.reply_pending = 1'b0;
                end
            end
            default: ;
        endcase
        if (door_state.door_is_open && door_state.mode != MODE_OPEN &&
            ms_passed(it.now_ms, door_state.door_move_time, door_cfg.door_open_ms)) begin
            res.servo_command = SERVO_CLOSE;
            door_state.door_is_open = 1'b0;
            res.status_shown = ST_AUTOCLOSED;
            enter_idle(it.now_ms);
            door_state.grant_hold = 1'b0;
            door_state.reply_pending = 1'b0;
        end
        res.mode_now = door_state.mode;
        return res;
    endfunction

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 149) == 0) begin
            calm = $urandom_range(20, 60);
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_outputs.push_back(tick_outputs(t_item'(s_axis_tdata[$bits(t_item)-1:0])));
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_queue.size() != 0) begin
                    s_axis_tdata <= InDataW'(tick_queue.pop_front());
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                if (expected_outputs.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (got.publish_motion !== want.publish_motion) begin
                        $error("publish_motion: expected %0d, got %0d",
                               want.publish_motion, got.publish_motion);
                        mismatches++;
                    end
                    if (got.servo_command !== want.servo_command) begin
                        $error("servo_command: expected %0d, got %0d",
                               want.servo_command, got.servo_command);
                        mismatches++;
                    end
                    if (got.send_alert !== want.send_alert) begin
                        $error("send_alert: expected %0d, got %0d",
                               want.send_alert, got.send_alert);
                        mismatches++;
                    end
                    if (got.status_shown !== want.status_shown) begin
                        $error("status_shown: expected %0d, got %0d",
                               want.status_shown, got.status_shown);
                        mismatches++;
                    end
                    if (got.mode_now !== want.mode_now) begin
                        $error("mode_now: expected %0d, got %0d",
                               want.mode_now, got.mode_now);
                        mismatches++;
                    end
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("door_access_sequencer: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [TimeW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_SAMPLE_INTERVAL: door_cfg.sample_interval_ms = val;
            REG_REPLY_TIMEOUT:   door_cfg.reply_timeout_ms = val;
            REG_DOOR_OPEN:       door_cfg.door_open_ms = val;
            default:             door_cfg.alert_timeout_ms = val;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input logic [TimeW-1:0] sample, input logic [TimeW-1:0] reply,
                              input logic [TimeW-1:0] door, input logic [TimeW-1:0] alert);
        write_reg(REG_SAMPLE_INTERVAL, sample);
        write_reg(REG_REPLY_TIMEOUT, reply);
        write_reg(REG_DOOR_OPEN, door);
        write_reg(REG_ALERT_TIMEOUT, alert);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (tick_queue.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_tick(input logic [TimeW-1:0] now, input logic motion,
                             input logic arrived, input logic [1:0] code);
        t_item it;
        it.now_ms = now;
        it.motion_level = motion;
        it.reply_arrived = arrived;
        it.reply_code = code;
        tick_queue.push_back(it);
    endtask

    task automatic gen_ticks(input int n, input logic [TimeW-1:0] max_step);
        int unsigned r;
        logic [1:0]  code;
        logic        arrived;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                clock_ms = $urandom;
            end else if (r < 9) begin
                clock_ms = clock_ms - 1;
            end else if (r < 11) begin
                clock_ms = clock_ms + $urandom;
            end else begin
                clock_ms = clock_ms + $urandom_range(0, max_step);
            end
            if ($urandom_range(0, 2) == 0) motion_lvl = ~motion_lvl;
            arrived = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 19);
            if (r < 7) code = CODE_OK;
            else if (r < 12) code = CODE_NO;
            else if (r < 16) code = CODE_NO_DETECT;
            else code = CODE_UNKNOWN;
            push_tick(clock_ms, motion_lvl, arrived, code);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_tick(32'd0,     1'b0, 1'b0, CODE_UNKNOWN);
        push_tick(32'd500,   1'b1, 1'b0, CODE_UNKNOWN);
        push_tick(32'd600,   1'b1, 1'b1, CODE_UNKNOWN);
        push_tick(32'd700,   1'b1, 1'b1, CODE_OK);
        push_tick(32'd800,   1'b0, 1'b1, CODE_NO);
        push_tick(32'd5700,  1'b0, 1'b0, CODE_UNKNOWN);
        push_tick(32'd6300,  1'b0, 1'b0, CODE_UNKNOWN);
        push_tick(32'd6900,  1'b1, 1'b0, CODE_UNKNOWN);
        push_tick(32'd7000,  1'b1, 1'b1, CODE_NO);
        push_tick(32'd8900,  1'b0, 1'b0, CODE_UNKNOWN);
        push_tick(32'd9500,  1'b1, 1'b0, CODE_UNKNOWN);
        push_tick(32'd19500, 1'b1, 1'b0, CODE_UNKNOWN);
        push_tick(32'd20100, 1'b0, 1'b0, CODE_UNKNOWN);
        push_tick(32'd20700, 1'b1, 1'b0, CODE_UNKNOWN);
        push_tick(32'd20800, 1'b1, 1'b1, CODE_NO_DETECT);
        push_tick(32'd31400, 1'b0, 1'b0, CODE_UNKNOWN);
        push_tick(32'd32000, 1'b1, 1'b0, CODE_UNKNOWN);
        push_tick(32'd33000, 1'b1, 1'b1, CODE_OK);
        // alert latch expires with the door still open
        push_tick(32'd37000, 1'b0, 1'b0, CODE_UNKNOWN);
        push_tick(32'd37500, 1'b1, 1'b0, CODE_UNKNOWN);
        push_tick(32'd37600, 1'b1, 1'b1, CODE_OK);
        push_tick(32'd37700, 1'b1, 1'b1, CODE_NO);
        push_tick(32'd38000, 1'b0, 1'b0, CODE_UNKNOWN);
        push_tick(32'hFFFF_FFFF, 1'b1, 1'b1, CODE_NO_DETECT);
        push_tick(32'd0,     1'b0, 1'b0, CODE_UNKNOWN);
        wait_drained();

        clock_ms = $urandom;
        set_timing(32'd5, 32'd80, 32'd40, 32'd120);
        gen_ticks(60, 32'd25);
        wait_drained();
        gen_ticks(60, 32'd25);
        wait_drained();

        set_timing(32'd0, 32'd0, 32'd0, 32'd0);
        gen_ticks(80, 32'd10);
        wait_drained();

        set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        gen_ticks(40, 32'd20);
        wait_drained();

        set_timing(32'd3, 32'd200, 32'd400, 32'd60);
        gen_ticks(120, 32'd20);
        wait_drained();

        set_timing($urandom, $urandom, $urandom, $urandom);
        gen_ticks(60, 32'hFFFF_FFFF);
        wait_drained();

        set_timing(32'd10, 32'd150, 32'd60, 32'd250);
        gen_ticks(200, 32'd30);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("door_access_sequencer: match");
        end else begin
            $display("door_access_sequencer: mismatch");
        end
        $finish;
    end

endmodule
